@@ hdl/cmt_pkg.sv @@
// shared types, constants and saturating adders for the cell moment tally block
// no dependencies; imported by every module of the block
`default_nettype none

package cmt_pkg;

  localparam int WORD_W     = 64;
  localparam int TALLIES    = 6;
  localparam int ROW_W      = WORD_W * TALLIES;
  localparam int CELLS_DEF  = 1024;
  localparam int GROUPS_DEF = 4;
  localparam int WIDE_W     = 256;

  // word slots inside one row
  localparam int T_CNT  = 0;
  localparam int T_MASS = 1;
  localparam int T_PX   = 2;
  localparam int T_PY   = 3;
  localparam int T_PZ   = 4;
  localparam int T_SUM  = 5;

  // item functions
  localparam logic [1:0] FN_TALLY = 2'd0;
  localparam logic [1:0] FN_CLEAR = 2'd1;
  localparam logic [1:0] FN_READ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_TPREF = 2'd1;
  localparam logic [1:0] CFG_PPREF = 2'd2;
  localparam logic [1:0] CFG_NSAMP = 2'd3;

  localparam logic [31:0] PREF_RST  = 32'd65536;
  localparam logic [15:0] NSAMP_RST = 16'd1;

  // one readout job handed to the arithmetic unit
  typedef struct packed {
    logic [63:0] n;
    logic [63:0] m;
    logic [63:0] px;
    logic [63:0] py;
    logic [63:0] pz;
    logic [63:0] s;
    logic        mode;
    logic [31:0] tpref;
    logic [31:0] ppref;
    logic [31:0] weight;
    logic [31:0] volume;
    logic [15:0] nsamp;
  } ro_req_t;

  function automatic logic [63:0] uadd_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  function automatic logic [63:0] sadd_sat(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

endpackage

`default_nettype wire

@@ hdl/cell_moment_tally_thermal_top.sv @@
// top level of the cell moment tally: item control, tally update, config and result register
// uses cmt_pkg, cmt_tally_mem and cmt_ro_unit
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  func, cell, group, mass, velocity, weight, volume
//  out_     output     out_valid/out_stall result_value, empty_cell
//  cfg_     input      cfg_we             cfg_index, cfg_wdata
//
// one item at a time: a tally passes MUL1, MUL2 and WB, a clear zeroes the GROUPS rows of its
// cell, and a readout (temperature or pressure) runs two bit-serial passes of the 256-bit
// divider and the limb-serial 32x32 multiplier; a zero mass sum skips the first pass
// an empty-cell or out-of-range readout does not start the arithmetic unit
// after reset a clearing pass zeroes all CELLS*GROUPS rows of the memory, one row per cycle
// config writes are taken throughout; the result register lets a new item in while a
// result beat is stalled
`default_nettype none

module cell_moment_tally_thermal_top
  import cmt_pkg::*;
#(
  parameter int CELLS  = CELLS_DEF,
  parameter int GROUPS = GROUPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_func,
  input  wire logic [9:0]         in_cell_index,
  input  wire logic signed [2:0]  in_group_index,
  input  wire logic               in_cell_in_group,
  input  wire logic [23:0]        in_particle_mass,
  input  wire logic signed [15:0] in_velocity_x,
  input  wire logic signed [15:0] in_velocity_y,
  input  wire logic signed [15:0] in_velocity_z,
  input  wire logic [31:0]        in_cell_weight,
  input  wire logic [31:0]        in_cell_volume,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [63:0]      out_result_value,
  output logic                    out_empty_cell,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata
);

  localparam int DEPTH  = CELLS * GROUPS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_MUL2 = 4'd3;
  localparam logic [3:0] S_WB   = 4'd4;
  localparam logic [3:0] S_CLR  = 4'd5;
  localparam logic [3:0] S_RO   = 4'd6;
  localparam logic [3:0] S_RUN  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]  state_r, state_nxt;
  logic [ADDR_W-1:0] init_r, init_nxt;
  logic [GRP_W-1:0]  gcnt_r, gcnt_nxt;

  // config
  logic        mode_r;
  logic [31:0] tpref_r, ppref_r;
  logic [15:0] nsamp_r;

  // item held during its work
  logic [9:0]         it_cell_r;
  logic [ADDR_W-1:0]  it_addr_r;
  logic [23:0]        it_m_r;
  logic signed [15:0] it_vx_r, it_vy_r, it_vz_r;
  logic [31:0]        it_w_r, it_vol_r;

  logic signed [40:0] px_r, py_r, pz_r;
  logic [31:0]        vsq_r;
  logic [55:0]        mv_r;

  logic [63:0] res_val_r, res_val_nxt;
  logic        res_empty_r, res_empty_nxt;
  logic        out_valid_r;
  logic [63:0] out_val_r;
  logic        out_empty_r;

  logic              accept, gvalid, cvalid;
  logic [31:0]       in_addr_w, clr_addr_w;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ROW_W-1:0]  mem_wdata, rd_row;
  logic              load_out;

  logic signed [40:0] px_c, py_c, pz_c;
  logic signed [31:0] sqx, sqy, sqz;
  logic [63:0]        wb_word [TALLIES];

  ro_req_t     ro_req;
  logic        ro_start, ro_busy, ro_done;
  logic [63:0] ro_value;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign gvalid    = !in_group_index[2] && (32'(in_group_index[1:0]) < GROUPS);
  assign cvalid    = (32'(in_cell_index) < CELLS);
  assign in_addr_w = 32'(in_cell_index) * 32'(GROUPS) + 32'(in_group_index[1:0]);
  assign clr_addr_w = 32'(it_cell_r) * 32'(GROUPS) + 32'(gcnt_r);
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  assign out_valid        = out_valid_r;
  assign out_result_value = out_val_r;
  assign out_empty_cell   = out_empty_r;

  // tally products
  always_comb begin
    px_c = $signed({1'b0, it_m_r}) * it_vx_r;
    py_c = $signed({1'b0, it_m_r}) * it_vy_r;
    pz_c = $signed({1'b0, it_m_r}) * it_vz_r;
    sqx  = it_vx_r * it_vx_r;
    sqy  = it_vy_r * it_vy_r;
    sqz  = it_vz_r * it_vz_r;
  end

  // read-modify-write of one row
  always_comb begin
    wb_word[T_CNT]  = uadd_sat(rd_row[T_CNT*WORD_W +: WORD_W], 64'd1);
    wb_word[T_MASS] = uadd_sat(rd_row[T_MASS*WORD_W +: WORD_W], 64'(it_m_r));
    wb_word[T_PX]   = sadd_sat(rd_row[T_PX*WORD_W +: WORD_W], 64'(px_r));
    wb_word[T_PY]   = sadd_sat(rd_row[T_PY*WORD_W +: WORD_W], 64'(py_r));
    wb_word[T_PZ]   = sadd_sat(rd_row[T_PZ*WORD_W +: WORD_W], 64'(pz_r));
    wb_word[T_SUM]  = uadd_sat(rd_row[T_SUM*WORD_W +: WORD_W], 64'(mv_r));
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = it_addr_r;
    mem_wdata = '0;
    case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_r;
      end
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_w[ADDR_W-1:0];
      end
      S_WB: begin
        mem_we    = 1'b1;
        mem_wdata = {wb_word[T_SUM], wb_word[T_PZ], wb_word[T_PY],
                     wb_word[T_PX], wb_word[T_MASS], wb_word[T_CNT]};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    ro_req.n      = rd_row[T_CNT*WORD_W +: WORD_W];
    ro_req.m      = rd_row[T_MASS*WORD_W +: WORD_W];
    ro_req.px     = rd_row[T_PX*WORD_W +: WORD_W];
    ro_req.py     = rd_row[T_PY*WORD_W +: WORD_W];
    ro_req.pz     = rd_row[T_PZ*WORD_W +: WORD_W];
    ro_req.s      = rd_row[T_SUM*WORD_W +: WORD_W];
    ro_req.mode   = mode_r;
    ro_req.tpref  = tpref_r;
    ro_req.ppref  = ppref_r;
    ro_req.weight = it_w_r;
    ro_req.volume = it_vol_r;
    ro_req.nsamp  = nsamp_r;
  end

  always_comb begin
    state_nxt     = state_r;
    init_nxt      = init_r;
    gcnt_nxt      = gcnt_r;
    res_val_nxt   = res_val_r;
    res_empty_nxt = res_empty_r;
    mem_re        = 1'b0;
    ro_start      = 1'b0;

    case (state_r)
      S_INIT: begin
        init_nxt = init_r + 1'b1;
        if (32'(init_r) == DEPTH - 1) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          case (in_func)
            FN_TALLY: begin
              if (gvalid && cvalid && in_cell_in_group) begin
                mem_re    = 1'b1;
                state_nxt = S_MUL1;
              end
            end
            FN_CLEAR: begin
              if (cvalid) begin
                gcnt_nxt  = '0;
                state_nxt = S_CLR;
              end
            end
            FN_READ: begin
              if (gvalid && cvalid) begin
                mem_re    = 1'b1;
                state_nxt = S_RO;
              end else begin
                res_val_nxt   = '0;
                res_empty_nxt = 1'b1;
                state_nxt     = S_DONE;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_WB;
      S_WB:   state_nxt = S_IDLE;

      S_CLR: begin
        gcnt_nxt = gcnt_r + 1'b1;
        if (32'(gcnt_r) == GROUPS - 1) begin
          state_nxt = S_IDLE;
        end
      end

      S_RO: begin
        if (ro_req.n == 64'd0) begin
          res_val_nxt   = '0;
          res_empty_nxt = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          ro_start  = 1'b1;
          state_nxt = S_RUN;
        end
      end

      S_RUN: begin
        if (ro_done) begin
          res_val_nxt   = ro_value;
          res_empty_nxt = 1'b0;
          state_nxt     = S_DONE;
        end
      end

      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_r      <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= 1'b0;
      tpref_r     <= PREF_RST;
      ppref_r     <= PREF_RST;
      nsamp_r     <= NSAMP_RST;
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:  mode_r  <= cfg_wdata[0];
          CFG_TPREF: tpref_r <= cfg_wdata;
          CFG_PPREF: ppref_r <= cfg_wdata;
          CFG_NSAMP: nsamp_r <= cfg_wdata[15:0];
          default:   mode_r  <= mode_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    gcnt_r      <= gcnt_nxt;
    res_val_r   <= res_val_nxt;
    res_empty_r <= res_empty_nxt;
    if (accept) begin
      it_cell_r <= in_cell_index;
      it_addr_r <= in_addr_w[ADDR_W-1:0];
      it_m_r    <= in_particle_mass;
      it_vx_r   <= in_velocity_x;
      it_vy_r   <= in_velocity_y;
      it_vz_r   <= in_velocity_z;
      it_w_r    <= in_cell_weight;
      it_vol_r  <= in_cell_volume;
    end
    if (state_r == S_MUL1) begin
      px_r  <= px_c;
      py_r  <= py_c;
      pz_r  <= pz_c;
      vsq_r <= 32'(sqx) + 32'(sqy) + 32'(sqz);
    end
    if (state_r == S_MUL2) begin
      mv_r <= 56'(it_m_r) * 56'(vsq_r);
    end
    if (load_out) begin
      out_val_r   <= res_val_r;
      out_empty_r <= res_empty_r;
    end
  end

  cmt_tally_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (in_addr_w[ADDR_W-1:0]),
    .rdata (rd_row)
  );

  cmt_ro_unit u_ro (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ro_start),
    .req   (ro_req),
    .busy  (ro_busy),
    .done  (ro_done),
    .value (ro_value)
  );

  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_INIT || state_r == S_CLR || state_r == S_WB))
    else $error("memory write outside init, clear or write-back");

  a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    ro_start |-> !ro_busy)
    else $error("readout started while unit busy");

  a_done_run: assert property (@(posedge clk) disable iff (!rst_n)
    ro_done |-> (state_r == S_RUN))
    else $error("readout result with no readout pending");

  a_load_beat: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (out_valid_r && state_r == S_IDLE))
    else $error("result beat not presented");

endmodule

`default_nettype wire

@@ hdl/cmt_tally_mem.sv @@
// tally memory: one row of six 64-bit sums per cell and group
// single write port, single read port with registered read data; uses cmt_pkg
`default_nettype none

module cmt_tally_mem
  import cmt_pkg::*;
#(
  parameter int DEPTH  = CELLS_DEF * GROUPS_DEF,
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [ROW_W-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [ROW_W-1:0]  rdata
);

  logic [ROW_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/cmt_ro_unit.sv @@
// readout arithmetic: thermal energy, scaling and division
// one 32x32 multiplier run limb by limb, one bit-serial 256/64 divider; uses cmt_pkg
`default_nettype none

module cmt_ro_unit
  import cmt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire ro_req_t     req,
  output logic             busy,
  output logic             done,
  output logic [63:0]      value
);

  localparam logic [3:0] A_IDLE = 4'd0;
  localparam logic [3:0] A_LD   = 4'd1;
  localparam logic [3:0] A_MAC  = 4'd2;
  localparam logic [3:0] A_DIV  = 4'd3;
  localparam logic [3:0] A_DIFF = 4'd4;
  localparam logic [3:0] A_SH   = 4'd5;
  localparam logic [3:0] A_SAT  = 4'd6;

  localparam logic [2:0] PH_SQ = 3'd0;
  localparam logic [2:0] PH_DQ = 3'd1;
  localparam logic [2:0] PH_MP = 3'd2;
  localparam logic [2:0] PH_MW = 3'd3;
  localparam logic [2:0] PH_DE = 3'd4;

  logic [3:0]        st_r, st_nxt;
  logic [2:0]        ph_r, ph_nxt;
  logic [2:0]        op_r, op_nxt;
  logic [2:0]        j_r, j_nxt;
  logic              k_r, k_nxt;
  logic [31:0]       m_r, m_nxt;
  logic [31:0]       c_r, c_nxt;
  logic [WIDE_W-1:0] x_r, x_nxt;
  logic [WIDE_W-1:0] acc_r, acc_nxt;
  logic [63:0]       rem_r, rem_nxt;
  logic [63:0]       d_r, d_nxt;
  logic [7:0]        cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic [63:0]       mag_r [3];
  logic [63:0]       mag_nxt [3];
  logic [47:0]       volns_r, volns_nxt;
  ro_req_t           req_r, req_nxt;
  logic              done_r, done_nxt;
  logic [63:0]       val_r, val_nxt;

  logic [2:0]   xi;
  logic [31:0]  xl, al;
  logic [63:0]  mac_t;
  logic [64:0]  dv_t;
  logic         dv_ge;
  logic [1:0]   comp;
  logic [128:0] s_ext, q_ext;
  logic         q_gt;
  logic [63:0]  sat_v;
  logic         sat_hi;
  logic [31:0]  vol_eff;
  logic [15:0]  ns_eff;

  assign busy  = (st_r != A_IDLE);
  assign done  = done_r;
  assign value = val_r;

  always_comb begin
    xi     = j_r - {2'b00, k_r};
    xl     = x_r[{xi, 5'b00000} +: 32];
    al     = acc_r[{j_r, 5'b00000} +: 32];
    mac_t  = 64'(xl) * 64'(m_r) + 64'(al) + 64'(c_r);
    dv_t   = {rem_r, acc_r[WIDE_W-1]};
    dv_ge  = (dv_t >= {1'b0, d_r});
    comp   = op_r[2:1];
    s_ext  = {65'd0, req_r.s};
    q_ext  = {1'b0, acc_r[127:0]};
    q_gt   = (q_ext > s_ext);
    sat_v  = acc_r[63:0];
    sat_hi = |acc_r[WIDE_W-1:64];
    vol_eff = (req.volume == 32'd0) ? 32'd1 : req.volume;
    ns_eff  = (req.nsamp == 16'd0) ? 16'd1 : req.nsamp;
  end

  always_comb begin
    st_nxt    = st_r;
    ph_nxt    = ph_r;
    op_nxt    = op_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    m_nxt     = m_r;
    c_nxt     = c_r;
    x_nxt     = x_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    d_nxt     = d_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    volns_nxt = volns_r;
    req_nxt   = req_r;
    done_nxt  = 1'b0;
    val_nxt   = val_r;

    case (st_r)
      A_IDLE: begin
        if (start) begin
          req_nxt    = req;
          mag_nxt[0] = req.px[63] ? (64'd0 - req.px) : req.px;
          mag_nxt[1] = req.py[63] ? (64'd0 - req.py) : req.py;
          mag_nxt[2] = req.pz[63] ? (64'd0 - req.pz) : req.pz;
          volns_nxt  = 48'(vol_eff) * 48'(ns_eff);
          acc_nxt    = '0;
          op_nxt     = 3'd0;
          ph_nxt     = PH_SQ;
          // zero mass sum leaves the quotient at zero
          st_nxt     = (req.m == 64'd0) ? A_DIFF : A_LD;
        end
      end

      A_LD: begin
        x_nxt  = {192'd0, mag_r[comp]};
        m_nxt  = op_r[0] ? mag_r[comp][63:32] : mag_r[comp][31:0];
        k_nxt  = op_r[0];
        j_nxt  = {2'b00, op_r[0]};
        c_nxt  = '0;
        st_nxt = A_MAC;
      end

      A_MAC: begin
        acc_nxt[{j_r, 5'b00000} +: 32] = mac_t[31:0];
        c_nxt = mac_t[63:32];
        j_nxt = j_r + 3'd1;
        if (j_r == 3'd7) begin
          case (ph_r)
            PH_SQ: begin
              if (op_r == 3'd5) begin
                d_nxt   = req_r.m;
                rem_nxt = '0;
                cnt_nxt = '0;
                ph_nxt  = PH_DQ;
                st_nxt  = A_DIV;
              end else begin
                op_nxt = op_r + 3'd1;
                st_nxt = A_LD;
              end
            end
            PH_MP: begin
              if (!req_r.mode) begin
                d_nxt  = req_r.n;
                st_nxt = A_SH;
              end else begin
                x_nxt  = acc_nxt;
                acc_nxt = '0;
                m_nxt  = req_r.weight;
                j_nxt  = 3'd0;
                k_nxt  = 1'b0;
                c_nxt  = '0;
                ph_nxt = PH_MW;
              end
            end
            default: begin
              d_nxt  = 64'(volns_r);
              st_nxt = A_SH;
            end
          endcase
        end
      end

      A_SH: begin
        // times 2^16 before the final division
        acc_nxt = {acc_r[WIDE_W-17:0], 16'd0};
        rem_nxt = '0;
        cnt_nxt = '0;
        ph_nxt  = PH_DE;
        st_nxt  = A_DIV;
      end

      A_DIV: begin
        rem_nxt = dv_ge ? 64'(dv_t - {1'b0, d_r}) : dv_t[63:0];
        acc_nxt = {acc_r[WIDE_W-2:0], dv_ge};
        cnt_nxt = cnt_r + 8'd1;
        if (cnt_r == 8'd255) begin
          st_nxt = (ph_r == PH_DQ) ? A_DIFF : A_SAT;
        end
      end

      A_DIFF: begin
        neg_nxt = q_gt;
        x_nxt   = {128'd0, q_gt ? 128'(q_ext - s_ext) : 128'(s_ext - q_ext)};
        acc_nxt = '0;
        m_nxt   = req_r.mode ? req_r.ppref : req_r.tpref;
        j_nxt   = 3'd0;
        k_nxt   = 1'b0;
        c_nxt   = '0;
        ph_nxt  = PH_MP;
        st_nxt  = A_MAC;
      end

      A_SAT: begin
        if (!neg_r) begin
          val_nxt = (sat_hi || sat_v[63]) ? {1'b0, {63{1'b1}}} : sat_v;
        end else begin
          val_nxt = (sat_hi || sat_v > {1'b1, 63'd0}) ? {1'b1, 63'd0} : (64'd0 - sat_v);
        end
        done_nxt = 1'b1;
        st_nxt   = A_IDLE;
      end

      default: begin
        st_nxt = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ph_r    <= ph_nxt;
    op_r    <= op_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    m_r     <= m_nxt;
    c_r     <= c_nxt;
    x_r     <= x_nxt;
    acc_r   <= acc_nxt;
    rem_r   <= rem_nxt;
    d_r     <= d_nxt;
    cnt_r   <= cnt_nxt;
    neg_r   <= neg_nxt;
    mag_r   <= mag_nxt;
    volns_r <= volns_nxt;
    req_r   <= req_nxt;
    val_r   <= val_nxt;
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == A_DIV) |-> (d_r != 64'd0))
    else $error("divider running with zero divisor");

  a_done_from_sat: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(st_r) == A_SAT))
    else $error("done without saturation step");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && st_r == A_IDLE) |=> (st_r == A_LD || st_r == A_DIFF))
    else $error("readout job not taken");

endmodule

`default_nettype wire
